// File: src/tdlc_pkg.sv
// Shared types and codes for the timed dead-man lift controller.
package tdlc_pkg;

    localparam logic [2:0] FUNC_TICK = 3'd0;
    localparam logic [2:0] FUNC_STOP = 3'd1;
    localparam logic [2:0] FUNC_TOGGLE = 3'd2;
    localparam logic [2:0] FUNC_SET = 3'd3;
    localparam logic [2:0] FUNC_RECEIVE = 3'd4;

    localparam logic [1:0] OP_IDLE = 2'd0;
    localparam logic [1:0] OP_OPENING = 2'd1;
    localparam logic [1:0] OP_CLOSING = 2'd2;

    localparam logic [1:0] CMD_UP = 2'd0;
    localparam logic [1:0] CMD_DOWN = 2'd1;
    localparam logic [1:0] CMD_BEACON = 2'd2;

    localparam logic [2:0] CFG_REMOTE_CODE = 3'd0;
    localparam logic [2:0] CFG_FRAME_INTERVAL = 3'd1;
    localparam logic [2:0] CFG_OPEN_DURATION = 3'd2;
    localparam logic [2:0] CFG_CLOSE_DURATION = 3'd3;
    localparam logic [2:0] CFG_OPEN_MARGIN = 3'd4;
    localparam logic [2:0] CFG_CLOSE_MARGIN = 3'd5;

    localparam logic [31:0] IDLE_TIMEOUT_MS = 32'd1000;
    localparam logic [31:0] PUBLISH_PERIOD_MS = 32'd1000;
    localparam int DIV_STEPS = 16;
    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [31:0] remote_code;
        logic [15:0] frame_interval_ms;
        logic [19:0] open_duration_ms;
        logic [19:0] close_duration_ms;
        logic [19:0] open_margin_ms;
        logic [19:0] close_margin_ms;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic pre;
        logic div_step;
        logic post;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

    typedef enum logic [1:0] {
        POST_NONE = 2'd0,
        POST_TICK = 2'd1,
        POST_START = 2'd2,
        POST_RXPUB = 2'd3
    } t_post;

endpackage

// File: src/timed_deadman_lift_controller.sv
// Top level of the timed dead-man lift controller with its register bank.
// Each request is latched on acceptance, prepared, passed through the travel divider
// when the position has to be advanced by elapsed time, and then registered as a result.
// The travel divider forms two quotient bits of elapsed_ms * 2^32 / duration per cycle.
// A new request is taken once the previous one has been handed to the result register,
// which may still wait for the consumer, and a result held by the consumer delays the
// handoff. Configuration writes are accepted on every cycle and must only be made while
// no request is in flight.
module timed_deadman_lift_controller
    import tdlc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_target_pos,
    input  logic        i_frame_ok,
    input  logic [31:0] i_frame_code,
    input  logic [1:0]  i_frame_cmd,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_send_frame,
    output logic        o_send_up,
    output logic [15:0] o_position_out,
    output logic [1:0]  o_operation_out,
    output logic        o_publish,
    output logic        o_frame_accepted,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.remote_code <= '0;
            r_cfg.frame_interval_ms <= 16'd150;
            r_cfg.open_duration_ms <= 20'd30000;
            r_cfg.close_duration_ms <= 20'd30000;
            r_cfg.open_margin_ms <= 20'd2000;
            r_cfg.close_margin_ms <= 20'd2000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REMOTE_CODE: r_cfg.remote_code <= i_cfg_data;
                CFG_FRAME_INTERVAL: r_cfg.frame_interval_ms <= i_cfg_data[15:0];
                CFG_OPEN_DURATION: r_cfg.open_duration_ms <= i_cfg_data[19:0];
                CFG_CLOSE_DURATION: r_cfg.close_duration_ms <= i_cfg_data[19:0];
                CFG_OPEN_MARGIN: r_cfg.open_margin_ms <= i_cfg_data[19:0];
                CFG_CLOSE_MARGIN: r_cfg.close_margin_ms <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    tdlc_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_status(status),
        .o_cmd(cmd)
    );

    tdlc_datapath u_datapath (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_cmd(cmd),
        .o_status(status),
        .i_func(i_func),
        .i_target_pos(i_target_pos),
        .i_frame_ok(i_frame_ok),
        .i_frame_code(i_frame_code),
        .i_frame_cmd(i_frame_cmd),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_send_frame(o_send_frame),
        .o_send_up(o_send_up),
        .o_position_out(o_position_out),
        .o_operation_out(o_operation_out),
        .o_publish(o_publish),
        .o_frame_accepted(o_frame_accepted)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while previous one still in progress");

    a_up_needs_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_send_up || o_send_frame))
        else $error("frame direction reported without a frame");

    a_operation_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_operation_out == OP_IDLE || o_operation_out == OP_OPENING
                         || o_operation_out == OP_CLOSING))
        else $error("result carries an undefined operation");
`endif

endmodule

// File: src/tdlc_ctrl.sv
// Sequencing state machine for one request: latch, prepare, divide, finish.
module tdlc_ctrl
    import tdlc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PRE  = 4'b0010,
        S_DIV  = 4'b0100,
        S_POST = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                o_cmd.pre = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (i_status.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/tdlc_datapath.sv
// Lift state, travel divider and result register.
module tdlc_datapath
    import tdlc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_target_pos,
    input  logic        i_frame_ok,
    input  logic [31:0] i_frame_code,
    input  logic [1:0]  i_frame_cmd,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic        o_send_frame,
    output logic        o_send_up,
    output logic [15:0] o_position_out,
    output logic [1:0]  o_operation_out,
    output logic        o_publish,
    output logic        o_frame_accepted
);

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    logic [2:0]  r_func;
    logic [15:0] r_tpos;
    logic        r_ok;
    logic [31:0] r_code;
    logic [1:0]  r_fcmd;

    logic [31:0] r_pos, n_pos;
    logic [31:0] r_target, n_target;
    logic [1:0]  r_op, n_op;
    logic [1:0]  r_prev, n_prev;
    logic        r_rd, n_rd;
    logic [31:0] r_stx, n_stx;
    logic [31:0] r_unap, n_unap;
    logic [20:0] r_run, n_run;
    logic        r_armed, n_armed;
    logic [19:0] r_esl, n_esl;
    logic [31:0] r_srx, n_srx;
    logic [31:0] r_spub, n_spub;

    logic        r_send, n_send;
    logic        r_up, n_up;
    logic        r_pub, n_pub;
    logic        r_acc, n_acc;
    logic        r_travel, n_travel;
    t_post       r_post, n_post;
    logic [1:0]  r_dir, n_dir;

    logic [19:0]      r_rem, n_rem;
    logic [31:0]      r_quo, n_quo;
    logic             r_full, n_full;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic        r_out_valid;
    logic        r_o_send, r_o_up, r_o_pub, r_o_acc;
    logic [15:0] r_o_pos;
    logic [1:0]  r_o_op;

    logic [19:0] dur;
    logic        out_free;

    assign dur = (r_op == OP_OPENING)
               ? ((i_cfg.open_duration_ms == '0) ? 20'd1 : i_cfg.open_duration_ms)
               : ((i_cfg.close_duration_ms == '0) ? 20'd1 : i_cfg.close_duration_ms);
    assign out_free = !r_out_valid || i_out_ready;
    assign o_status.out_free = out_free;
    assign o_status.div_done = !r_travel || (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_comb begin
        logic [31:0] v_unap;
        logic [31:0] v_pos;
        logic [31:0] v_req;
        logic [1:0]  v_dir;
        logic        v_start;
        logic        v_halt;
        logic        v_reached;
        logic [1:0]  v_rop;
        logic [20:0] t1, t2;
        logic [19:0] r1;
        logic        b1, b2;
        logic [32:0] delta;
        logic [32:0] sum;

        n_pos = r_pos; n_target = r_target; n_op = r_op; n_prev = r_prev;
        n_rd = r_rd; n_stx = r_stx; n_unap = r_unap; n_run = r_run;
        n_armed = r_armed; n_esl = r_esl; n_srx = r_srx; n_spub = r_spub;
        n_send = r_send; n_up = r_up; n_pub = r_pub; n_acc = r_acc;
        n_travel = r_travel; n_post = r_post; n_dir = r_dir;
        n_rem = r_rem; n_quo = r_quo; n_full = r_full; n_cnt = r_cnt;
        v_unap = r_unap; v_pos = r_pos; v_req = {r_tpos, r_tpos};
        v_dir = OP_IDLE; v_start = 1'b0; v_halt = 1'b0; v_reached = 1'b0;
        v_rop = (r_fcmd == CMD_UP) ? OP_OPENING : OP_CLOSING;
        t1 = '0; t2 = '0; r1 = '0; b1 = 1'b0; b2 = 1'b0;
        delta = '0; sum = '0;

        if (i_cmd.load) begin
            n_send = 1'b0; n_up = 1'b0; n_pub = 1'b0; n_acc = 1'b0;
            n_travel = 1'b0; n_post = POST_NONE;
        end

        if (i_cmd.pre) begin
            case (r_func)
                FUNC_TICK: begin
                    n_stx = sat_inc(r_stx);
                    n_srx = sat_inc(r_srx);
                    n_spub = sat_inc(r_spub);
                    if (r_op != OP_IDLE) begin
                        v_unap = sat_inc(r_unap);
                        n_unap = v_unap;
                    end
                    n_run = (r_run == '0) ? r_run : r_run - 21'd1;
                    if (r_armed) begin
                        n_esl = (r_esl == '0) ? r_esl : r_esl - 20'd1;
                    end
                    if (r_rd) begin
                        if (n_srx > IDLE_TIMEOUT_MS) begin
                            n_rd = 1'b0; n_op = OP_IDLE; n_pub = 1'b1;
                        end
                    end else if (r_op != OP_IDLE) begin
                        if (n_stx >= {16'd0, i_cfg.frame_interval_ms}) begin
                            n_send = 1'b1;
                            n_up = (r_op == OP_OPENING);
                            n_stx = '0;
                        end
                        n_travel = 1'b1;
                        n_post = POST_TICK;
                    end
                end
                FUNC_STOP: begin
                    n_op = OP_IDLE; n_armed = 1'b0; n_rd = 1'b0; n_pub = 1'b1;
                end
                FUNC_TOGGLE: begin
                    if (r_op != OP_IDLE) begin
                        n_op = OP_IDLE; n_armed = 1'b0; n_rd = 1'b0; n_pub = 1'b1;
                    end else if (r_pos == '0 || r_prev == OP_CLOSING) begin
                        n_target = '1; v_dir = OP_OPENING; v_start = 1'b1;
                    end else begin
                        n_target = '0; v_dir = OP_CLOSING; v_start = 1'b1;
                    end
                end
                FUNC_SET: begin
                    if (v_req == r_pos) begin
                        if (v_req == '1 || v_req == '0) begin
                            n_target = v_req;
                            v_dir = (v_req == '0) ? OP_CLOSING : OP_OPENING;
                            v_start = 1'b1;
                        end
                    end else begin
                        n_target = v_req;
                        v_dir = (v_req < r_pos) ? OP_CLOSING : OP_OPENING;
                        v_start = 1'b1;
                    end
                end
                FUNC_RECEIVE: begin
                    if (r_ok && r_code == i_cfg.remote_code) begin
                        n_acc = 1'b1;
                        if (r_op == OP_IDLE || r_rd) begin
                            if (r_fcmd == CMD_UP || r_fcmd == CMD_DOWN) begin
                                if (!r_rd || r_op != v_rop) begin
                                    n_rd = 1'b1; n_op = v_rop; n_prev = v_rop;
                                    n_unap = '0; n_pub = 1'b1; n_spub = '0;
                                end else begin
                                    n_travel = 1'b1;
                                    n_post = POST_RXPUB;
                                end
                                n_srx = '0;
                            end else if (r_fcmd == CMD_BEACON) begin
                                if (r_rd) begin
                                    n_rd = 1'b0; n_op = OP_IDLE; n_pub = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (v_start && !(v_dir == r_op && !r_rd)) begin
                n_travel = (r_op != OP_IDLE);
                n_post = POST_START;
                n_dir = v_dir;
            end
            n_full = (v_unap >= {12'd0, dur});
            n_rem = n_full ? 20'd0 : v_unap[19:0];
            n_quo = '0;
            n_cnt = '0;
        end

        if (i_cmd.div_step && r_travel) begin
            t1 = {r_rem, 1'b0};
            b1 = (t1 >= {1'b0, dur});
            r1 = b1 ? 20'(t1 - {1'b0, dur}) : t1[19:0];
            t2 = {r1, 1'b0};
            b2 = (t2 >= {1'b0, dur});
            n_rem = b2 ? 20'(t2 - {1'b0, dur}) : t2[19:0];
            n_quo = {r_quo[29:0], b1, b2};
            n_cnt = r_cnt + CNT_W'(1);
        end

        if (i_cmd.post) begin
            if (r_travel) begin
                delta = r_full ? {1'b1, 32'd0} : {1'b0, r_quo};
                if (r_op == OP_OPENING) begin
                    sum = {1'b0, r_pos} + delta;
                    v_pos = sum[32] ? '1 : sum[31:0];
                end else begin
                    v_pos = (delta >= {1'b0, r_pos}) ? 32'd0 : 32'(({1'b0, r_pos}) - delta);
                end
                n_unap = '0;
            end
            case (r_post)
                POST_TICK: begin
                    v_reached = (r_op == OP_OPENING) ? (v_pos >= r_target)
                                                     : (v_pos <= r_target);
                    if (r_armed) begin
                        if (r_esl == '0) begin
                            v_pos = r_target; v_halt = 1'b1;
                        end
                    end else if (v_reached) begin
                        if (r_target == '1 || r_target == '0) begin
                            n_armed = 1'b1;
                            n_esl = (r_op == OP_OPENING) ? i_cfg.open_margin_ms
                                                         : i_cfg.close_margin_ms;
                        end else begin
                            v_halt = 1'b1;
                        end
                    end else if (r_run == '0) begin
                        v_halt = 1'b1;
                    end
                    if (v_halt) begin
                        n_op = OP_IDLE; n_armed = 1'b0; n_rd = 1'b0; n_pub = 1'b1;
                    end else if (r_spub > PUBLISH_PERIOD_MS) begin
                        n_pub = 1'b1; n_spub = '0;
                    end
                end
                POST_START: begin
                    n_rd = 1'b0; n_prev = r_dir; n_op = r_dir; n_unap = '0;
                    n_run = (r_dir == OP_OPENING)
                          ? {1'b0, i_cfg.open_duration_ms} + {1'b0, i_cfg.open_margin_ms}
                          : {1'b0, i_cfg.close_duration_ms} + {1'b0, i_cfg.close_margin_ms};
                    n_armed = 1'b0;
                    n_send = 1'b1; n_up = (r_dir == OP_OPENING);
                    n_stx = '0; n_pub = 1'b1;
                end
                POST_RXPUB: begin
                    if (r_spub > PUBLISH_PERIOD_MS) begin
                        n_pub = 1'b1; n_spub = '0;
                    end
                end
                default: ;
            endcase
            n_pos = v_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_tpos <= i_target_pos;
            r_ok <= i_frame_ok;
            r_code <= i_frame_code;
            r_fcmd <= i_frame_cmd;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_full <= n_full;
        r_dir <= n_dir;
        if (i_cmd.post) begin
            r_o_send <= n_send;
            r_o_up <= n_send && n_up;
            r_o_pos <= n_pos[31:16];
            r_o_op <= n_op;
            r_o_pub <= n_pub;
            r_o_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_target <= '0; r_op <= OP_IDLE; r_prev <= OP_IDLE;
            r_rd <= 1'b0; r_stx <= '0; r_unap <= '0; r_run <= '0;
            r_armed <= 1'b0; r_esl <= '0; r_srx <= '0; r_spub <= '0;
            r_send <= 1'b0; r_up <= 1'b0; r_pub <= 1'b0; r_acc <= 1'b0;
            r_travel <= 1'b0; r_post <= POST_NONE; r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos <= n_pos; r_target <= n_target; r_op <= n_op; r_prev <= n_prev;
            r_rd <= n_rd; r_stx <= n_stx; r_unap <= n_unap; r_run <= n_run;
            r_armed <= n_armed; r_esl <= n_esl; r_srx <= n_srx; r_spub <= n_spub;
            r_send <= n_send; r_up <= n_up; r_pub <= n_pub; r_acc <= n_acc;
            r_travel <= n_travel; r_post <= n_post; r_cnt <= n_cnt;
            if (i_cmd.post) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_send_frame = r_o_send;
    assign o_send_up = r_o_up;
    assign o_position_out = r_o_pos;
    assign o_operation_out = r_o_op;
    assign o_publish = r_o_pub;
    assign o_frame_accepted = r_o_acc;

endmodule

// File: dv/tb_timed_deadman_lift_controller.sv
// Self-checking testbench for the timed dead-man lift controller with a built-in predictor.
`timescale 1ns / 1ps

module tb_timed_deadman_lift_controller;
    import tdlc_pkg::*;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] target_pos;
        logic        frame_ok;
        logic [31:0] frame_code;
        logic [1:0]  frame_cmd;
    } t_req;

    typedef struct packed {
        logic        send_frame;
        logic        send_up;
        logic [15:0] position;
        logic [1:0]  operation;
        logic        publish;
        logic        accepted;
    } t_resp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_func;
    logic [15:0] i_target_pos;
    logic        i_frame_ok;
    logic [31:0] i_frame_code;
    logic [1:0]  i_frame_cmd;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_send_frame;
    logic        o_send_up;
    logic [15:0] o_position_out;
    logic [1:0]  o_operation_out;
    logic        o_publish;
    logic        o_frame_accepted;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    timed_deadman_lift_controller u_top (.*);

    // Predictor state.
    logic [31:0] m_code;
    logic [31:0] m_interval;
    logic [31:0] m_open_dur;
    logic [31:0] m_close_dur;
    logic [31:0] m_open_margin;
    logic [31:0] m_close_margin;
    logic [31:0] m_pos;
    logic [31:0] m_target;
    logic [1:0]  m_op;
    logic [1:0]  m_prev_dir;
    logic        m_remote;
    logic [31:0] m_since_tx;
    logic [31:0] m_unapplied;
    logic [31:0] m_run_left;
    logic        m_armed;
    logic [31:0] m_stop_left;
    logic [31:0] m_since_rx;
    logic [31:0] m_since_pub;
    logic        r_send;
    logic        r_up;
    logic        r_pub;
    logic        r_acc;

    t_req   pending_reqs[$];
    t_resp  expected_resps[$];
    int     cycle_count;
    int     fail_count;
    int     in_gap;
    int     out_gap;

    function automatic logic [31:0] sat_up(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [31:0] sat_down(logic [31:0] v);
        return (v == 32'd0) ? v : v - 32'd1;
    endfunction

    function automatic void advance_position();
        logic [31:0] dur;
        logic [64:0] delta;
        logic [64:0] sum;
        if (m_op == OP_OPENING) begin
            dur = m_open_dur;
        end else if (m_op == OP_CLOSING) begin
            dur = m_close_dur;
        end else begin
            return;
        end
        if (dur == 0) dur = 1;
        if (m_unapplied >= dur) delta = 65'h1_0000_0000;
        else delta = ({33'd0, m_unapplied} << 32) / dur;
        if (m_op == OP_OPENING) begin
            sum = {33'd0, m_pos} + delta;
            m_pos = (sum > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        end else begin
            m_pos = (delta >= {33'd0, m_pos}) ? 32'd0 : m_pos - delta[31:0];
        end
        m_unapplied = 0;
    endfunction

    function automatic void halt_lift();
        m_op = OP_IDLE;
        m_armed = 0;
        m_remote = 0;
        r_pub = 1;
    endfunction

    function automatic void begin_travel(logic [1:0] dir);
        if (dir == m_op && !m_remote) return;
        advance_position();
        m_remote = 0;
        m_prev_dir = dir;
        m_op = dir;
        m_unapplied = 0;
        if (dir == OP_OPENING) m_run_left = m_open_dur + m_open_margin;
        else m_run_left = m_close_dur + m_close_margin;
        m_armed = 0;
        r_send = 1;
        r_up = (dir == OP_OPENING);
        m_since_tx = 0;
        r_pub = 1;
    endfunction

    function automatic void process_tick();
        logic hit;
        m_since_tx = sat_up(m_since_tx);
        m_since_rx = sat_up(m_since_rx);
        m_since_pub = sat_up(m_since_pub);
        if (m_op != OP_IDLE) m_unapplied = sat_up(m_unapplied);
        m_run_left = sat_down(m_run_left);
        if (m_armed) m_stop_left = sat_down(m_stop_left);
        if (m_remote) begin
            if (m_since_rx > IDLE_TIMEOUT_MS) begin
                m_remote = 0;
                m_op = OP_IDLE;
                r_pub = 1;
            end
            return;
        end
        if (m_op == OP_IDLE) return;
        if (m_since_tx >= m_interval) begin
            r_send = 1;
            r_up = (m_op == OP_OPENING);
            m_since_tx = 0;
        end
        advance_position();
        hit = (m_op == OP_OPENING) ? (m_pos >= m_target) : (m_pos <= m_target);
        if (m_armed) begin
            if (m_stop_left == 0) begin
                m_pos = m_target;
                halt_lift();
                return;
            end
        end else if (hit) begin
            if (m_target == 32'hFFFF_FFFF || m_target == 32'd0) begin
                m_armed = 1;
                m_stop_left = (m_op == OP_OPENING) ? m_open_margin : m_close_margin;
            end else begin
                halt_lift();
                return;
            end
        end else if (m_run_left == 0) begin
            halt_lift();
            return;
        end
        if (m_since_pub > PUBLISH_PERIOD_MS) begin
            r_pub = 1;
            m_since_pub = 0;
        end
    endfunction

    function automatic void process_frame(t_req r);
        logic [1:0] dir;
        if (!r.frame_ok || r.frame_code != m_code) return;
        r_acc = 1;
        if (m_op != OP_IDLE && !m_remote) return;
        if (r.frame_cmd == CMD_UP || r.frame_cmd == CMD_DOWN) begin
            dir = (r.frame_cmd == CMD_UP) ? OP_OPENING : OP_CLOSING;
            if (!m_remote || m_op != dir) begin
                m_remote = 1;
                m_op = dir;
                m_prev_dir = dir;
                m_unapplied = 0;
                r_pub = 1;
                m_since_pub = 0;
            end else begin
                advance_position();
                if (m_since_pub > PUBLISH_PERIOD_MS) begin
                    r_pub = 1;
                    m_since_pub = 0;
                end
            end
            m_since_rx = 0;
        end else if (r.frame_cmd == CMD_BEACON && m_remote) begin
            m_remote = 0;
            m_op = OP_IDLE;
            r_pub = 1;
        end
    endfunction

    function automatic t_resp predict_lift(t_req r);
        logic [31:0] req_pos;
        t_resp res;
        r_send = 0;
        r_up = 0;
        r_pub = 0;
        r_acc = 0;
        case (r.func)
            FUNC_TICK: process_tick();
            FUNC_STOP: halt_lift();
            FUNC_TOGGLE: begin
                if (m_op != OP_IDLE) begin
                    halt_lift();
                end else if (m_pos == 0 || m_prev_dir == OP_CLOSING) begin
                    m_target = 32'hFFFF_FFFF;
                    begin_travel(OP_OPENING);
                end else begin
                    m_target = 0;
                    begin_travel(OP_CLOSING);
                end
            end
            FUNC_SET: begin
                req_pos = {r.target_pos, r.target_pos};
                if (req_pos == m_pos) begin
                    if (req_pos == 32'hFFFF_FFFF || req_pos == 0) begin
                        m_target = req_pos;
                        begin_travel(req_pos == 0 ? OP_CLOSING : OP_OPENING);
                    end
                end else begin
                    m_target = req_pos;
                    begin_travel(req_pos < m_pos ? OP_CLOSING : OP_OPENING);
                end
            end
            FUNC_RECEIVE: process_frame(r);
            default: ;
        endcase
        res.send_frame = r_send;
        res.send_up = r_send & r_up;
        res.position = m_pos[31:16];
        res.operation = m_op;
        res.publish = r_pub;
        res.accepted = r_acc;
        return res;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
            in_gap <= 0;
        end else if (i_in_valid && o_in_ready) begin
            expected_resps.push_back(predict_lift({i_func, i_target_pos, i_frame_ok,
                                                   i_frame_code, i_frame_cmd}));
            if (pending_reqs.size() > 0 && in_gap == 0 && ($urandom_range(0, 3) == 0)) begin
                {i_func, i_target_pos, i_frame_ok, i_frame_code, i_frame_cmd}
                    <= pending_reqs.pop_front();
            end else begin
                i_in_valid <= 0;
                in_gap <= $urandom_range(0, 11);
            end
        end else if (!i_in_valid) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                {i_func, i_target_pos, i_frame_ok, i_frame_code, i_frame_cmd}
                    <= pending_reqs.pop_front();
                i_in_valid <= 1;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_resp got;
        t_resp exp_r;
        if (!i_rst_n) begin
            i_out_ready <= 0;
            out_gap <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = {o_send_frame, o_send_up, o_position_out, o_operation_out,
                       o_publish, o_frame_accepted};
                if (expected_resps.size() == 0) begin
                    $error("unexpected result %h", got);
                    fail_count++;
                end else begin
                    exp_r = expected_resps.pop_front();
                    if (got.send_frame !== exp_r.send_frame) begin
                        $error("send_frame exp %h got %h", exp_r.send_frame, got.send_frame);
                        fail_count++;
                    end
                    if (got.send_up !== exp_r.send_up) begin
                        $error("send_up exp %h got %h", exp_r.send_up, got.send_up);
                        fail_count++;
                    end
                    if (got.position !== exp_r.position) begin
                        $error("position_out exp %h got %h", exp_r.position, got.position);
                        fail_count++;
                    end
                    if (got.operation !== exp_r.operation) begin
                        $error("operation_out exp %h got %h", exp_r.operation, got.operation);
                        fail_count++;
                    end
                    if (got.publish !== exp_r.publish) begin
                        $error("publish exp %h got %h", exp_r.publish, got.publish);
                        fail_count++;
                    end
                    if (got.accepted !== exp_r.accepted) begin
                        $error("frame_accepted exp %h got %h", exp_r.accepted, got.accepted);
                        fail_count++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_ready <= 0;
            end else if (o_out_valid && i_out_ready) begin
                out_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= 1;
            end
        end
    end

    function automatic t_req make_req(logic [2:0] f, logic [15:0] p, logic ok,
                                      logic [31:0] code, logic [1:0] cmd);
        t_req r;
        r.func = f;
        r.target_pos = p;
        r.frame_ok = ok;
        r.frame_code = code;
        r.frame_cmd = cmd;
        return r;
    endfunction

    task automatic add_ticks(int n);
        repeat (n) pending_reqs.push_back(make_req(FUNC_TICK, 16'($urandom), 1'($urandom),
                                                   $urandom, 2'($urandom)));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        case (idx)
            CFG_REMOTE_CODE: m_code = data;
            CFG_FRAME_INTERVAL: m_interval = {16'd0, data[15:0]};
            CFG_OPEN_DURATION: m_open_dur = {12'd0, data[19:0]};
            CFG_CLOSE_DURATION: m_close_dur = {12'd0, data[19:0]};
            CFG_OPEN_MARGIN: m_open_margin = {12'd0, data[19:0]};
            default: m_close_margin = {12'd0, data[19:0]};
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || expected_resps.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_phase(int n, logic [31:0] code);
        int k;
        int sel;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                add_ticks($urandom_range(1, 40));
            end else if (sel < 62) begin
                pending_reqs.push_back(make_req(FUNC_STOP, 16'($urandom), 1'($urandom),
                                                $urandom, 2'($urandom)));
            end else if (sel < 70) begin
                pending_reqs.push_back(make_req(FUNC_TOGGLE, 16'($urandom), 1'($urandom),
                                                $urandom, 2'($urandom)));
            end else if (sel < 80) begin
                pending_reqs.push_back(make_req(FUNC_SET,
                    ($urandom_range(0, 3) == 0)
                        ? (($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000)
                        : 16'($urandom),
                    1'($urandom), $urandom, 2'($urandom)));
            end else if (sel < 95) begin
                pending_reqs.push_back(make_req(FUNC_RECEIVE, 16'($urandom),
                    $urandom_range(0, 7) != 0,
                    ($urandom_range(0, 5) != 0) ? code : $urandom, 2'($urandom)));
            end else begin
                pending_reqs.push_back(make_req(3'($urandom_range(5, 7)), 16'($urandom),
                                                1'($urandom), $urandom, 2'($urandom)));
            end
        end
    endtask

    initial begin
        logic [31:0] code;
        int ph;
        cycle_count = 0;
        fail_count = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_out_ready = 0;
        i_func = 0;
        i_target_pos = 0;
        i_frame_ok = 0;
        i_frame_code = 0;
        i_frame_cmd = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        m_code = 0;
        m_interval = 150;
        m_open_dur = 30000;
        m_close_dur = 30000;
        m_open_margin = 2000;
        m_close_margin = 2000;
        m_pos = 0;
        m_target = 0;
        m_op = OP_IDLE;
        m_prev_dir = OP_IDLE;
        m_remote = 0;
        m_since_tx = 0;
        m_unapplied = 0;
        m_run_left = 0;
        m_armed = 0;
        m_stop_left = 0;
        m_since_rx = 0;
        m_since_pub = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed part on the reset settings, then small travel and zero intervals.
        pending_reqs.push_back(make_req(FUNC_RECEIVE, 0, 1, 0, CMD_BEACON));
        pending_reqs.push_back(make_req(FUNC_RECEIVE, 0, 0, 0, CMD_UP));
        pending_reqs.push_back(make_req(FUNC_SET, 16'h0000, 0, 0, 0));
        pending_reqs.push_back(make_req(FUNC_STOP, 0, 0, 0, 0));
        drain();
        write_reg(CFG_REMOTE_CODE, 32'hFFFF_FFFF);
        write_reg(CFG_FRAME_INTERVAL, 0);
        write_reg(CFG_OPEN_DURATION, 0);
        write_reg(CFG_CLOSE_DURATION, 20);
        write_reg(CFG_OPEN_MARGIN, 0);
        write_reg(CFG_CLOSE_MARGIN, 3);
        pending_reqs.push_back(make_req(FUNC_SET, 16'hFFFF, 1, 32'hFFFF_FFFF, 3));
        add_ticks(3);
        pending_reqs.push_back(make_req(FUNC_SET, 16'hFFFF, 0, 0, 0));
        pending_reqs.push_back(make_req(FUNC_SET, 16'h8000, 0, 0, 0));
        add_ticks(12);
        pending_reqs.push_back(make_req(FUNC_TOGGLE, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FUNC_RECEIVE, 0, 1, 32'hFFFF_FFFF, CMD_UP));
        pending_reqs.push_back(make_req(FUNC_STOP, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FUNC_RECEIVE, 0, 1, 32'hFFFF_FFFF, CMD_DOWN));
        add_ticks(2);
        pending_reqs.push_back(make_req(FUNC_RECEIVE, 0, 1, 32'hFFFF_FFFF, CMD_UP));
        pending_reqs.push_back(make_req(FUNC_RECEIVE, 0, 1, 32'hFFFF_FFFF, 2'd3));
        pending_reqs.push_back(make_req(3'd7, 16'hFFFF, 1, 32'hFFFF_FFFF, 2'd3));
        pending_reqs.push_back(make_req(FUNC_RECEIVE, 0, 1, 32'hFFFF_FFFF, CMD_BEACON));
        drain();

        for (ph = 0; ph < 6; ph++) begin
            code = $urandom;
            write_reg(CFG_REMOTE_CODE, code);
            write_reg(CFG_FRAME_INTERVAL, (ph == 5) ? 32'hFFFF : $urandom_range(0, 20));
            write_reg(CFG_OPEN_DURATION, (ph == 4) ? 32'hF_FFFF : $urandom_range(1, 300));
            write_reg(CFG_CLOSE_DURATION, (ph == 4) ? 32'hF_FFFF : $urandom_range(1, 300));
            write_reg(CFG_OPEN_MARGIN, (ph == 3) ? 32'hF_FFFF : $urandom_range(0, 40));
            write_reg(CFG_CLOSE_MARGIN, (ph == 3) ? 32'hF_FFFF : $urandom_range(0, 40));
            random_phase(($urandom_range(0, 1) == 1) ? 7 : 5, code);
            if (ph == 0) begin
                // A silent remote is followed until its timeout.
                pending_reqs.push_back(make_req(FUNC_STOP, 0, 0, 0, 0));
                pending_reqs.push_back(make_req(FUNC_RECEIVE, 0, 1, code, CMD_DOWN));
                add_ticks(1002);
            end
            drain();
            random_phase(6, code);
            drain();
        end
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: timed_deadman_lift_controller.f
src/tdlc_pkg.sv
src/tdlc_ctrl.sv
src/tdlc_datapath.sv
src/timed_deadman_lift_controller.sv
dv/tb_timed_deadman_lift_controller.sv
